>>> rtl/core/vpma_pkg.sv
// ----------------------------------------------------------------------------
// vpma_pkg
// Shared types, constants and helpers of the planar display memory core.
// ----------------------------------------------------------------------------
package vpma_pkg;

  // Words per plane; the window offset is folded into this range.
  localparam int unsigned PLANE_DEPTH = 65536;
  localparam int unsigned IdxW = $clog2(PLANE_DEPTH);
  // Offsets stay below 65536, so no conditional subtraction is needed to fold them.
  localparam int unsigned WrapSteps = 65535 / PLANE_DEPTH;

  // Entries of the queue between the decode front and the memory back.
  localparam int unsigned QueueDepth = 2;

  // Memory windows on the 20-bit host bus.
  localparam logic [19:0] WinBaseA0 = 20'ha_0000;
  localparam logic [19:0] WinBaseB0 = 20'hb_0000;
  localparam logic [19:0] WinBaseB8 = 20'hb_8000;
  localparam logic [19:0] WinSize128K = 20'h2_0000;
  localparam logic [19:0] WinSize64K = 20'h1_0000;
  localparam logic [19:0] WinSize32K = 20'h0_8000;

  localparam logic [7:0] ReadMissData = 8'hff;
  localparam logic [3:0] OddEvenPlanes = 4'h5;

  typedef enum logic [2:0] {
    CFG_PLANE_WRITE_ENABLE = 3'd0,
    CFG_MEMORY_MODE        = 3'd1,
    CFG_SET_RESET_PAIR     = 3'd2,
    CFG_COMPARE_PAIR       = 3'd3,
    CFG_ROTATE_AND_FUNC    = 3'd4,
    CFG_MAP_SELECTS        = 3'd5,
    CFG_GRAPHICS_MODE      = 3'd6,
    CFG_PIXEL_MASK         = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MISS_READ  = 2'd0,
    OP_MISS_WRITE = 2'd1,
    OP_READ       = 2'd2,
    OP_WRITE      = 2'd3
  } op_e;

  typedef struct packed {
    logic        opcode;
    logic [19:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       window_hit;
  } out_item_t;

  typedef struct packed {
    logic [3:0] plane_write_enable;
    logic [1:0] memory_mode;
    logic [7:0] set_reset_pair;
    logic [7:0] compare_pair;
    logic [4:0] rotate_and_function;
    logic [3:0] map_selects;
    logic [4:0] graphics_mode;
    logic [7:0] pixel_mask;
  } cfg_t;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic [1:0]      plane;
    logic [3:0]      pmask;
    logic [7:0]      data;
  } q_entry_t;

  // Folds a 16-bit plane offset into the plane depth.
  function automatic logic [IdxW-1:0] wrap_index(input logic [15:0] off);
    logic [16:0] v;
    v = {1'b0, off};
    for (int i = 0; i < WrapSteps; i++) begin
      if (v >= 17'(PLANE_DEPTH)) begin
        v = v - 17'(PLANE_DEPTH);
      end
    end
    return v[IdxW-1:0];
  endfunction

endpackage

>>> rtl/core/vga_planar_memory_access_core.sv
// ----------------------------------------------------------------------------
// vga_planar_memory_access_core
// Planar display memory: host byte reads and writes on four 64K planes.
//
// The input channel takes one host access (opcode, address, data); the output
// channel returns one result per access (read_data, window_hit), in order.
// The configuration channel writes one of the eight graphics registers by
// index and is always ready; write it only while no access is in flight.
// An accepted access enters a two-entry queue; the back end pops it once the
// output slot is free and no read is pending. Misses and writes load their
// result into the output register when popped; a read waits in the read state
// on the registered plane RAM read before the latches load and the result
// forms. Writes and misses run at one per cycle while the receiver takes
// results; a read holds the back end in the read state until its result forms.
// After reset the latches are zero and the planes are swept to zero, one word
// per cycle through all PLANE_DEPTH words, with input ready low; configuration
// writes are taken meanwhile. When the receiver stalls, the result holds in
// the output register, the queue fills and input ready drops.
// ----------------------------------------------------------------------------
module vga_planar_memory_access_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vpma_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vpma_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import vpma_pkg::*;

  cfg_t     cfg_q;
  q_entry_t push_entry;
  q_entry_t head_entry;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  logic     clear_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_write_enable <= 4'hf;
      cfg_q.memory_mode <= '0;
      cfg_q.set_reset_pair <= '0;
      cfg_q.compare_pair <= '0;
      cfg_q.rotate_and_function <= '0;
      cfg_q.map_selects <= '0;
      cfg_q.graphics_mode <= '0;
      cfg_q.pixel_mask <= 8'hff;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PLANE_WRITE_ENABLE: cfg_q.plane_write_enable <= cfg_data_i[3:0];
        CFG_MEMORY_MODE:        cfg_q.memory_mode <= cfg_data_i[1:0];
        CFG_SET_RESET_PAIR:     cfg_q.set_reset_pair <= cfg_data_i;
        CFG_COMPARE_PAIR:       cfg_q.compare_pair <= cfg_data_i;
        CFG_ROTATE_AND_FUNC:    cfg_q.rotate_and_function <= cfg_data_i[4:0];
        CFG_MAP_SELECTS:        cfg_q.map_selects <= cfg_data_i[3:0];
        CFG_GRAPHICS_MODE:      cfg_q.graphics_mode <= cfg_data_i[4:0];
        CFG_PIXEL_MASK:         cfg_q.pixel_mask <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vpma_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .clear_busy_i(clear_busy),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  vpma_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  vpma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .entry_i     (head_entry),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .clear_busy_o(clear_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/core/vpma_ram.sv
// ----------------------------------------------------------------------------
// vpma_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
module vpma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/core/vpma_front.sv
// ----------------------------------------------------------------------------
// vpma_front
// Accepts host accesses, decodes the window and the plane addressing.
// ----------------------------------------------------------------------------
module vpma_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpma_pkg::in_item_t in_item_i,
  input  vpma_pkg::cfg_t     cfg_i,
  input  logic               q_full_i,
  input  logic               clear_busy_i,
  output logic               push_o,
  output vpma_pkg::q_entry_t entry_o
);
  import vpma_pkg::*;

  logic [19:0] base;
  logic [19:0] size;
  logic [19:0] diff;
  logic        hit;
  logic [15:0] off;
  logic [15:0] plane_off;
  logic [1:0]  plane;
  logic [3:0]  pmask;
  logic        chain4;
  logic        oddeven;

  always_comb begin
    case (cfg_i.map_selects[1:0])
      2'd1: begin
        base = WinBaseA0;
        size = WinSize64K;
      end
      2'd2: begin
        base = WinBaseB0;
        size = WinSize32K;
      end
      2'd3: begin
        base = WinBaseB8;
        size = WinSize32K;
      end
      default: begin
        base = WinBaseA0;
        size = WinSize128K;
      end
    endcase
  end

  assign diff = in_item_i.address - base;
  assign hit = (in_item_i.address >= base) && (diff < size);
  // The upper half of the 128K window aliases the lower half.
  assign off = diff[15:0];

  assign chain4 = cfg_i.memory_mode[1];
  assign oddeven = !cfg_i.memory_mode[0] && cfg_i.graphics_mode[4];

  always_comb begin
    if (chain4) begin
      plane = off[1:0];
      pmask = cfg_i.plane_write_enable & (4'h1 << off[1:0]);
      plane_off = {2'b00, off[15:2]};
    end else if (oddeven) begin
      plane = {cfg_i.map_selects[3], off[0]};
      pmask = cfg_i.plane_write_enable & (OddEvenPlanes << off[0]);
      plane_off = {1'b0, off[15:1]};
    end else begin
      plane = cfg_i.map_selects[3:2];
      pmask = cfg_i.plane_write_enable;
      plane_off = off;
    end
  end

  always_comb begin
    if (!hit) begin
      entry_o.op = in_item_i.opcode ? OP_MISS_WRITE : OP_MISS_READ;
    end else begin
      entry_o.op = in_item_i.opcode ? OP_WRITE : OP_READ;
    end
    entry_o.idx = wrap_index(plane_off);
    entry_o.plane = plane;
    entry_o.pmask = pmask;
    entry_o.data = in_item_i.data;
  end

  assign in_ready_o = !clear_busy_i && !q_full_i;
  assign push_o = in_valid_i && in_ready_o;

endmodule

>>> rtl/core/vpma_queue.sv
// ----------------------------------------------------------------------------
// vpma_queue
// Small flop-based FIFO of decoded accesses between front and back.
// ----------------------------------------------------------------------------
module vpma_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vpma_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output vpma_pkg::q_entry_t entry_o,
  output logic               full_o,
  output logic               empty_o
);
  import vpma_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_entry_t          slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/vpma_back.sv
// ----------------------------------------------------------------------------
// vpma_back
// Executes decoded accesses on the four planes and owns the latches.
// ----------------------------------------------------------------------------
module vpma_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vpma_pkg::cfg_t      cfg_i,
  input  vpma_pkg::q_entry_t  entry_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                clear_busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vpma_pkg::out_item_t out_item_o
);
  import vpma_pkg::*;

  localparam logic BK_RUN = 1'b0;
  localparam logic BK_READ = 1'b1;

  localparam logic [1:0] WMODE_1 = 2'd1;
  localparam logic [1:0] WMODE_2 = 2'd2;
  localparam logic [1:0] WMODE_3 = 2'd3;

  localparam logic [1:0] LOP_AND = 2'd1;
  localparam logic [1:0] LOP_OR = 2'd2;
  localparam logic [1:0] LOP_XOR = 2'd3;

  logic            state_q, state_d;
  logic            clearing_q;
  logic [IdxW-1:0] clr_addr_q;
  logic [1:0]      rd_plane_q;
  logic [31:0]     latch_q;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic            slot_free;
  logic            out_load;
  out_item_t       out_d;
  logic [IdxW-1:0] ram_addr;
  logic [3:0]      ram_we;
  logic [7:0]      ram_wdata [4];
  logic [7:0]      ram_rdata [4];
  logic [7:0]      wr_lane [4];
  logic [7:0]      rot;
  logic [7:0]      bmask;
  logic [7:0]      cmp_res;
  logic [7:0]      rd_res;

  function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] w;
    w = {v, v} >> n;
    return w[7:0];
  endfunction

  // Write data path, one lane per plane.
  assign rot = ror8(entry_i.data, cfg_i.rotate_and_function[2:0]);
  assign bmask = (cfg_i.graphics_mode[1:0] == WMODE_3) ? (cfg_i.pixel_mask & rot)
                                                       : cfg_i.pixel_mask;

  always_comb begin
    logic [7:0] lat;
    logic [7:0] src;
    logic [7:0] res;
    for (int p = 0; p < 4; p++) begin
      lat = latch_q[8*p +: 8];
      if (cfg_i.graphics_mode[1:0] == WMODE_2) begin
        src = {8{entry_i.data[p]}};
      end else if (cfg_i.graphics_mode[1:0] == WMODE_3 || cfg_i.set_reset_pair[4+p]) begin
        src = {8{cfg_i.set_reset_pair[p]}};
      end else begin
        src = rot;
      end
      case (cfg_i.rotate_and_function[4:3])
        LOP_AND: res = src & lat;
        LOP_OR:  res = src | lat;
        LOP_XOR: res = src ^ lat;
        default: res = src;
      endcase
      res = (res & bmask) | (lat & ~bmask);
      wr_lane[p] = (cfg_i.graphics_mode[1:0] == WMODE_1) ? lat : res;
    end
  end

  // Read result from the word that the memory returns in the read state.
  always_comb begin
    cmp_res = 8'hff;
    for (int p = 0; p < 4; p++) begin
      if (cfg_i.compare_pair[4+p]) begin
        cmp_res = cmp_res & ~(ram_rdata[p] ^ {8{cfg_i.compare_pair[p]}});
      end
    end
    rd_res = cfg_i.graphics_mode[3] ? cmp_res : ram_rdata[rd_plane_q];
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o = (state_q == BK_RUN) && !clearing_q && !q_empty_i && slot_free;
  assign ram_addr = clearing_q ? clr_addr_q : entry_i.idx;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      ram_we[p] = clearing_q || (pop_o && entry_i.op == OP_WRITE && entry_i.pmask[p]);
      ram_wdata[p] = clearing_q ? 8'h00 : wr_lane[p];
    end
  end

  always_comb begin
    state_d = state_q;
    out_load = 1'b0;
    out_d = '0;
    case (state_q)
      BK_RUN: begin
        if (pop_o) begin
          case (entry_i.op)
            OP_MISS_READ: begin
              out_load = 1'b1;
              out_d.read_data = ReadMissData;
            end
            OP_MISS_WRITE: begin
              out_load = 1'b1;
            end
            OP_WRITE: begin
              out_load = 1'b1;
              out_d.window_hit = 1'b1;
            end
            default: begin
              state_d = BK_READ;
            end
          endcase
        end
      end
      default: begin
        // The slot was free or being drained when the read was issued.
        out_load = 1'b1;
        out_d.read_data = rd_res;
        out_d.window_hit = 1'b1;
        state_d = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_RUN;
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      latch_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == IdxW'(PLANE_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (state_q == BK_READ) begin
        latch_q <= {ram_rdata[3], ram_rdata[2], ram_rdata[1], ram_rdata[0]};
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.op == OP_READ) begin
      rd_plane_q <= entry_i.plane;
    end
    if (out_load) begin
      out_item_q <= out_d;
    end
  end

  for (genvar p = 0; p < 4; p++) begin : g_plane
    vpma_ram #(
      .Width(8),
      .Depth(PLANE_DEPTH)
    ) u_plane_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[p]),
      .addr_i (ram_addr),
      .wdata_i(ram_wdata[p]),
      .rdata_o(ram_rdata[p])
    );
  end

  assign clear_busy_o = clearing_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

endmodule

>>> rtl/core/vpma_checker.sv
// ----------------------------------------------------------------------------
// vpma_checker
// Port-level checks of the planar memory core, bound to the top level.
// ----------------------------------------------------------------------------
module vpma_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vpma_pkg::out_item_t out_item_o
);
  import vpma_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // An access outside the window returns either the read miss byte or zero.
  a_miss_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.window_hit |->
      (out_item_o.read_data == ReadMissData || out_item_o.read_data == 8'h00))
    else $error("bad data on a window miss");

  // Right after reset the plane sweep runs and nothing is in flight.
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) == 1'b0 |-> !in_ready_o && !out_valid_o)
    else $error("core not idle while planes are cleared");

  // With no transfer in or out, the result channel cannot start from empty.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_valid_i && $past(!out_valid_o) && in_ready_o &&
    $past(in_ready_o) && $past(!in_valid_i) && $past(in_ready_o, 2) &&
    $past(!in_valid_i, 2) |=> !out_valid_o)
    else $error("result appeared without an accepted access");

endmodule

bind vga_planar_memory_access_core vpma_checker u_vpma_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the planar display memory core. Host byte accesses
// are sent over the input channel and every result is checked against an
// in-bench model of the four planes, the latches and the graphics registers.
// Directed tests cover window decode, write modes and addressing modes, and
// random traffic then runs under many register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vpma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam bit OPC_READ = 1'b0;
  localparam bit OPC_WRITE = 1'b1;

  localparam logic [1:0] WIN_A0_128K = 2'd0;
  localparam logic [1:0] WIN_A0_64K = 2'd1;
  localparam logic [1:0] WIN_B0_32K = 2'd2;
  localparam logic [1:0] WIN_B8_32K = 2'd3;

  localparam logic [1:0] WM_ROTATE = 2'd0;
  localparam logic [1:0] WM_LATCH = 2'd1;
  localparam logic [1:0] WM_COLOR = 2'd2;
  localparam logic [1:0] WM_MASKED_SR = 2'd3;

  localparam logic [1:0] LOP_PASS = 2'd0;
  localparam logic [1:0] LOP_AND = 2'd1;
  localparam logic [1:0] LOP_OR = 2'd2;
  localparam logic [1:0] LOP_XOR = 2'd3;

  localparam logic [7:0] MM_CHAIN4 = 8'h02;
  localparam logic [7:0] GM_COMPARE_READ = 8'h08;
  localparam logic [7:0] GM_HOST_ODD_EVEN = 8'h10;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic in_ready_o;
  logic out_valid_o;
  out_item_t out_item_o;
  logic cfg_ready_o;

  // Model state: one 32-bit word per offset, plane p in bits 8p+7..8p.
  bit [31:0] plane_model [PLANE_DEPTH];
  bit [31:0] latch_model;
  cfg_t regs;

  out_item_t expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hot_off = 0;
  int unsigned n_reads = 0;
  int unsigned n_writes = 0;
  int unsigned n_misses = 0;
  int unsigned n_cfg = 0;
  int unsigned n_settings = 0;

  vga_planar_memory_access_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [19:0] window_base(input logic [1:0] sel);
    case (sel)
      WIN_B0_32K: return 20'hB0000;
      WIN_B8_32K: return 20'hB8000;
      default:    return 20'hA0000;
    endcase
  endfunction

  function automatic logic [19:0] window_span(input logic [1:0] sel);
    case (sel)
      WIN_A0_64K: return 20'h10000;
      WIN_B0_32K, WIN_B8_32K: return 20'h08000;
      default:    return 20'h20000;
    endcase
  endfunction

  // Works out the result of one host access and updates planes and latches.
  function automatic out_item_t predict_access(input in_item_t acc);
    out_item_t res;
    logic [19:0] base;
    logic [19:0] span;
    logic [15:0] off;
    logic [1:0] rd_plane;
    logic [1:0] wmode;
    logic [3:0] planes;
    logic [7:0] rot;
    logic [7:0] mask;
    logic [7:0] lat;
    logic [7:0] src;
    logic [7:0] val;
    logic [31:0] word;
    int unsigned idx;
    bit chain4;
    bit oddeven;
    base = window_base(regs.map_selects[1:0]);
    span = window_span(regs.map_selects[1:0]);
    chain4 = regs.memory_mode[1];
    oddeven = !regs.memory_mode[0] && regs.graphics_mode[4];
    if (acc.address < base || acc.address - base >= span) begin
      res.read_data = (acc.opcode == OPC_WRITE) ? 8'h00 : 8'hFF;
      res.window_hit = 1'b0;
      return res;
    end
    off = 16'(acc.address - base);
    res.window_hit = 1'b1;
    res.read_data = 8'h00;

    if (acc.opcode == OPC_READ) begin
      if (chain4) begin
        rd_plane = off[1:0];
        off = off >> 2;
      end else if (oddeven) begin
        rd_plane = {regs.map_selects[3], off[0]};
        off = off >> 1;
      end else begin
        rd_plane = regs.map_selects[3:2];
      end
      latch_model = plane_model[off % PLANE_DEPTH];
      if (!regs.graphics_mode[3]) begin
        res.read_data = latch_model[8*rd_plane +: 8];
      end else begin
        res.read_data = 8'hFF;
        for (int p = 0; p < 4; p++) begin
          if (regs.compare_pair[4+p]) begin
            res.read_data &= ~(latch_model[8*p +: 8] ^ {8{regs.compare_pair[p]}});
          end
        end
      end
      return res;
    end

    planes = regs.plane_write_enable;
    if (chain4) begin
      planes &= 4'b0001 << off[1:0];
      off = off >> 2;
    end else if (oddeven) begin
      planes &= 4'h5 << off[0];
      off = off >> 1;
    end
    wmode = regs.graphics_mode[1:0];
    rot = 8'({acc.data, acc.data} >> regs.rotate_and_function[2:0]);
    mask = regs.pixel_mask;
    if (wmode == WM_MASKED_SR) begin
      mask &= rot;
    end
    idx = off % PLANE_DEPTH;
    word = plane_model[idx];
    for (int p = 0; p < 4; p++) begin
      if (planes[p]) begin
        lat = latch_model[8*p +: 8];
        if (wmode == WM_LATCH) begin
          val = lat;
        end else begin
          if (wmode == WM_COLOR) begin
            src = {8{acc.data[p]}};
          end else if (wmode == WM_MASKED_SR || regs.set_reset_pair[4+p]) begin
            src = {8{regs.set_reset_pair[p]}};
          end else begin
            src = rot;
          end
          case (regs.rotate_and_function[4:3])
            LOP_AND: val = src & lat;
            LOP_OR:  val = src | lat;
            LOP_XOR: val = src ^ lat;
            default: val = src;
          endcase
          val = (val & mask) | (lat & ~mask);
        end
        word[8*p +: 8] = val;
      end
    end
    plane_model[idx] = word;
    return res;
  endfunction

  // Holds one host access on the input channel until it is transferred.
  task automatic send_access(input in_item_t acc);
    int unsigned gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= acc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(predict_access(acc));
    if (acc.opcode == OPC_WRITE) n_writes++;
    else n_reads++;
  endtask

  task automatic host_access(input bit opc, input logic [19:0] addr, input logic [7:0] data);
    in_item_t acc;
    acc.opcode = opc;
    acc.address = addr;
    acc.data = data;
    send_access(acc);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic quiesce();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PLANE_WRITE_ENABLE: regs.plane_write_enable = val[3:0];
      CFG_MEMORY_MODE:        regs.memory_mode = val[1:0];
      CFG_SET_RESET_PAIR:     regs.set_reset_pair = val;
      CFG_COMPARE_PAIR:       regs.compare_pair = val;
      CFG_ROTATE_AND_FUNC:    regs.rotate_and_function = val[4:0];
      CFG_MAP_SELECTS:        regs.map_selects = val[3:0];
      CFG_GRAPHICS_MODE:      regs.graphics_mode = val[4:0];
      default:                regs.pixel_mask = val;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t random_access();
    in_item_t acc;
    logic [19:0] base;
    logic [19:0] span;
    int unsigned sel;
    base = window_base(regs.map_selects[1:0]);
    span = window_span(regs.map_selects[1:0]);
    sel = $urandom_range(99);
    acc.opcode = 1'($urandom_range(1));
    acc.data = 8'($urandom);
    // Most accesses stay near one offset so that reads see earlier writes.
    if (sel < 70) begin
      acc.address = 20'(base + (hot_off + $urandom_range(63)) % span);
    end else if (sel < 85) begin
      acc.address = 20'(base + $urandom_range(span - 1));
    end else if (sel < 92) begin
      case ($urandom_range(3))
        0:       acc.address = base - 20'd1;
        1:       acc.address = base;
        2:       acc.address = base + span - 20'd1;
        default: acc.address = base + span;
      endcase
    end else begin
      acc.address = 20'($urandom);
    end
    return acc;
  endfunction

  // Result channel: random back-pressure, then an in-order compare.
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_result
    out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_data %02h window_hit %0b",
                 $time, out_item_o.read_data, out_item_o.window_hit);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.read_data !== want.read_data) begin
          $display("%0t: read_data expected %02h, actual %02h",
                   $time, want.read_data, out_item_o.read_data);
          errors++;
        end
        if (out_item_o.window_hit !== want.window_hit) begin
          $display("%0t: window_hit expected %0b, actual %0b",
                   $time, want.window_hit, out_item_o.window_hit);
          errors++;
        end
        if (!want.window_hit) n_misses++;
      end
    end
  end

  task automatic test_window_decode();
    host_access(OPC_READ, 20'h00000, 8'h00);
    host_access(OPC_WRITE, 20'hFFFFF, 8'hFF);
    host_access(OPC_READ, 20'h9FFFF, 8'h00);
    host_access(OPC_WRITE, 20'hA0000, 8'h5A);
    host_access(OPC_READ, 20'hBFFFF, 8'h00);
    // The upper half of the 128K window folds onto the lower half.
    host_access(OPC_READ, 20'hB0000, 8'h00);
    host_access(OPC_READ, 20'hC0000, 8'h00);
    quiesce();
    write_reg(CFG_MAP_SELECTS, {4'h0, 2'd3, WIN_A0_64K});
    host_access(OPC_READ, 20'hAFFFF, 8'h00);
    host_access(OPC_READ, 20'hB0000, 8'h00);
    quiesce();
    write_reg(CFG_MAP_SELECTS, {4'h0, 2'd1, WIN_B0_32K});
    host_access(OPC_READ, 20'hB0000, 8'h00);
    host_access(OPC_READ, 20'hB8000, 8'h00);
    quiesce();
    write_reg(CFG_MAP_SELECTS, {4'h0, 2'd3, WIN_B8_32K});
    host_access(OPC_READ, 20'hB7FFF, 8'h00);
    host_access(OPC_READ, 20'hBFFFF, 8'h00);
    quiesce();
    write_reg(CFG_MAP_SELECTS, {4'h0, 2'd0, WIN_A0_128K});
  endtask

  task automatic test_write_modes();
    write_reg(CFG_GRAPHICS_MODE, {6'h00, WM_COLOR});
    write_reg(CFG_ROTATE_AND_FUNC, {3'b000, LOP_XOR, 3'd3});
    write_reg(CFG_PIXEL_MASK, 8'h0F);
    host_access(OPC_WRITE, 20'hA0001, 8'h05);
    host_access(OPC_READ, 20'hA0001, 8'h00);
    quiesce();
    write_reg(CFG_GRAPHICS_MODE, {6'h00, WM_MASKED_SR});
    write_reg(CFG_SET_RESET_PAIR, 8'hF3);
    host_access(OPC_WRITE, 20'hA0001, 8'hC3);
    quiesce();
    write_reg(CFG_GRAPHICS_MODE, {6'h00, WM_LATCH});
    host_access(OPC_WRITE, 20'hA0002, 8'h00);
    quiesce();
    write_reg(CFG_GRAPHICS_MODE, GM_COMPARE_READ);
    write_reg(CFG_COMPARE_PAIR, 8'hF5);
    host_access(OPC_READ, 20'hA0002, 8'h00);
    quiesce();
    // Write mode 0 with set/reset enabled on two planes and the AND function.
    write_reg(CFG_GRAPHICS_MODE, {6'h00, WM_ROTATE});
    write_reg(CFG_SET_RESET_PAIR, 8'hA5);
    write_reg(CFG_ROTATE_AND_FUNC, {3'b000, LOP_AND, 3'd7});
    write_reg(CFG_PIXEL_MASK, 8'hFF);
    host_access(OPC_WRITE, 20'hA0003, 8'h81);
    host_access(OPC_READ, 20'hA0003, 8'h00);
    quiesce();
  endtask

  task automatic test_addressing_modes();
    write_reg(CFG_SET_RESET_PAIR, 8'h00);
    write_reg(CFG_ROTATE_AND_FUNC, {3'b000, LOP_PASS, 3'd0});
    write_reg(CFG_MEMORY_MODE, MM_CHAIN4);
    host_access(OPC_WRITE, 20'hA0007, 8'h77);
    host_access(OPC_READ, 20'hA0007, 8'h00);
    quiesce();
    write_reg(CFG_MEMORY_MODE, 8'h00);
    write_reg(CFG_GRAPHICS_MODE, GM_HOST_ODD_EVEN);
    host_access(OPC_WRITE, 20'hA0009, 8'h99);
    host_access(OPC_READ, 20'hA0009, 8'h00);
    host_access(OPC_READ, 20'hA0008, 8'h00);
    quiesce();
  endtask

  // Each phase drains the block, loads a fresh register setting and sends a burst.
  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct,
                                     input int unsigned phases,
                                     input int unsigned per_phase);
    logic [7:0] v;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int ph = 0; ph < phases; ph++) begin
      quiesce();
      for (int i = 0; i < 8; i++) begin
        if (ph == 0) v = 8'h00;
        else if (ph == 1) v = 8'hFF;
        else if ($urandom_range(9) < 2) v = 8'h00;
        else if ($urandom_range(9) < 2) v = 8'hFF;
        else v = 8'($urandom);
        write_reg(cfg_idx_e'(i), v);
      end
      n_settings++;
      hot_off = $urandom_range(window_span(regs.map_selects[1:0]) - 1);
      repeat (per_phase) send_access(random_access());
    end
  endtask

  initial begin
    regs = '0;
    regs.plane_write_enable = 4'hF;
    regs.pixel_mask = 8'hFF;
    latch_model = '0;
    send_idle_pct = 35;
    recv_idle_pct = 50;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_window_decode();
    test_write_modes();
    test_addressing_modes();
    test_random_traffic(35, 50, 13, 50);
    test_random_traffic(50, 35, 13, 50);
    test_random_traffic(0, 0, 13, 50);

    quiesce();
    repeat (6) @(posedge clk_i);
    $display("Run covered %0d reads and %0d writes, %0d of them outside the window,",
             n_reads, n_writes, n_misses);
    $display("with %0d register writes over %0d random register settings.",
             n_cfg, n_settings);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
